// ===== design/vgm_pkg.sv =====
// Package: parse phase, event kinds, opcodes and beat types for the command stream parser
package vgm_pkg;

   typedef enum logic [2:0] {
      PH_OPCODE = 3'd0,
      PH_DATA   = 3'd1,
      PH_ADDR   = 3'd2,
      PH_FMDATA = 3'd3,
      PH_CNT_LO = 3'd4,
      PH_CNT_HI = 3'd5
   } phase_type;

   localparam logic [2:0] EV_TONE    = 3'd0;
   localparam logic [2:0] EV_FM0     = 3'd1;
   localparam logic [2:0] EV_FM1     = 3'd2;
   localparam logic [2:0] EV_WAIT    = 3'd3;
   localparam logic [2:0] EV_LOOP    = 3'd4;
   localparam logic [2:0] EV_END     = 3'd5;
   localparam logic [2:0] EV_HANDOFF = 3'd6;
   localparam logic [2:0] EV_ERROR   = 3'd7;

   localparam logic [7:0] OP_TONE_STEREO = 8'h4F;
   localparam logic [7:0] OP_TONE        = 8'h50;
   localparam logic [7:0] OP_FM_PORT0    = 8'h52;
   localparam logic [7:0] OP_FM_PORT1    = 8'h53;
   localparam logic [7:0] OP_WAIT_N      = 8'h61;
   localparam logic [7:0] OP_WAIT_735    = 8'h62;
   localparam logic [7:0] OP_WAIT_882    = 8'h63;
   localparam logic [7:0] OP_END         = 8'h66;
   localparam logic [7:0] OP_DATA_BLOCK  = 8'h67;
   localparam logic [7:0] OP_SEEK        = 8'hE0;
   localparam logic [3:0] NIB_WAIT_SHORT = 4'h7;
   localparam logic [3:0] NIB_PCM_WRITE  = 4'h8;

   localparam logic [7:0]  STEREO_ADDR = 8'h06;
   localparam logic [7:0]  PCM_ADDR    = 8'h2A;
   localparam logic [15:0] WAIT_NTSC   = 16'd735;
   localparam logic [15:0] WAIT_PAL    = 16'd882;

   typedef struct packed {
      logic [7:0] stream_byte;
      logic [7:0] pcm_byte;
   } req_beat_type;

   typedef struct packed {
      logic [2:0]  event_kind;
      logic [7:0]  reg_addr;
      logic [7:0]  write_data;
      logic [15:0] wait_samples;
      logic        pcm_advance;
   } rsp_beat_type;

   typedef struct packed {
      phase_type  phase;
      logic [7:0] opcode;
      logic [7:0] operand;
      logic       halted;
   } parse_state_type;

endpackage

// ===== design/vgm_command_stream_parser_top.sv =====
// Top level: command stream parser with input register, decoder and result register
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_stall | req_data (stream_byte, pcm_byte)
//   rsp     | out       | rsp_valid/rsp_stall | rsp_data (event, addr, data, wait, advance)
//   csr     | in        | csr_write_enable    | csr_write_data (loop_enable)
//
// One byte per cycle while not stalled: a beat is held in the input register, is
// decoded against the parse state, and any event lands in the result register.
// Synchronous active-high reset clears valids, parse state and loop_enable.
// A byte that completes no command passes without waiting on rsp_stall; an
// event waits only while the result register is full and stalled.
module vgm_command_stream_parser_top
   import vgm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_beat_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_beat_type rsp_data,
   input  logic         csr_write_enable,
   input  logic         csr_write_data
);

   logic            loop_enable_ff;
   logic            in_valid_ff;
   req_beat_type    in_beat_ff;
   parse_state_type state_ff;
   parse_state_type state_in;
   logic            out_valid_ff;
   rsp_beat_type    out_beat_ff;
   logic            emit;
   rsp_beat_type    event_beat;
   logic            out_free;
   logic            advance;

   vgm_decode u_decode (
      .state       (state_ff),
      .beat        (in_beat_ff),
      .loop_enable (loop_enable_ff),
      .state_next  (state_in),
      .emit        (emit),
      .event_out   (event_beat)
   );

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && (!emit || out_free);
   assign req_stall = in_valid_ff && !advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_beat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         loop_enable_ff <= 1'b0;
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         state_ff       <= '{phase: PH_OPCODE, opcode: 8'h00, operand: 8'h00, halted: 1'b0};
      end else begin
         if (csr_write_enable) begin
            loop_enable_ff <= csr_write_data;
         end
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            state_ff <= state_in;
         end
         if (advance && emit) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_beat_ff <= req_data;
      end
      if (advance && emit) begin
         out_beat_ff <= event_beat;
      end
   end

endmodule

// ===== design/vgm_decode.sv =====
// Decoder: one stream byte against the parse state gives the next state and an optional event
module vgm_decode
   import vgm_pkg::*;
(
   input  parse_state_type state,
   input  req_beat_type    beat,
   input  logic            loop_enable,
   output parse_state_type state_next,
   output logic            emit,
   output rsp_beat_type    event_out
);

   logic [7:0] b;

   assign b = beat.stream_byte;

   always_comb begin
      state_next = state;
      emit       = 1'b0;
      event_out  = '0;
      if (!state.halted) begin
         case (state.phase)
            PH_DATA: begin
               state_next.phase       = PH_OPCODE;
               emit                   = 1'b1;
               event_out.event_kind   = EV_TONE;
               event_out.reg_addr     = (state.opcode == OP_TONE_STEREO) ? STEREO_ADDR : 8'h00;
               event_out.write_data   = b;
               event_out.wait_samples = 16'd1;
            end
            PH_ADDR: begin
               state_next.operand = b;
               state_next.phase   = PH_FMDATA;
            end
            PH_FMDATA: begin
               state_next.phase       = PH_OPCODE;
               emit                   = 1'b1;
               event_out.event_kind   = (state.opcode == OP_FM_PORT1) ? EV_FM1 : EV_FM0;
               event_out.reg_addr     = state.operand;
               event_out.write_data   = b;
               event_out.wait_samples = 16'd1;
            end
            PH_CNT_LO: begin
               state_next.operand = b;
               state_next.phase   = PH_CNT_HI;
            end
            PH_CNT_HI: begin
               state_next.phase       = PH_OPCODE;
               emit                   = 1'b1;
               event_out.event_kind   = EV_WAIT;
               event_out.wait_samples = {b, state.operand};
            end
            default: begin
               state_next.phase  = PH_OPCODE;
               state_next.opcode = b;
               if (b == OP_TONE_STEREO || b == OP_TONE) begin
                  state_next.phase = PH_DATA;
               end else if (b == OP_FM_PORT0 || b == OP_FM_PORT1) begin
                  state_next.phase = PH_ADDR;
               end else if (b == OP_WAIT_N) begin
                  state_next.phase = PH_CNT_LO;
               end else if (b == OP_WAIT_735) begin
                  emit                   = 1'b1;
                  event_out.event_kind   = EV_WAIT;
                  event_out.wait_samples = WAIT_NTSC;
               end else if (b == OP_WAIT_882) begin
                  emit                   = 1'b1;
                  event_out.event_kind   = EV_WAIT;
                  event_out.wait_samples = WAIT_PAL;
               end else if (b[7:4] == NIB_WAIT_SHORT) begin
                  emit                   = 1'b1;
                  event_out.event_kind   = EV_WAIT;
                  event_out.wait_samples = {12'd0, b[3:0]} + 16'd1;
               end else if (b[7:4] == NIB_PCM_WRITE) begin
                  emit                   = 1'b1;
                  event_out.event_kind   = EV_FM0;
                  event_out.reg_addr     = PCM_ADDR;
                  event_out.write_data   = beat.pcm_byte;
                  event_out.wait_samples = {12'd0, b[3:0]};
                  event_out.pcm_advance  = 1'b1;
               end else if (b == OP_END) begin
                  emit = 1'b1;
                  if (loop_enable) begin
                     event_out.event_kind = EV_LOOP;
                  end else begin
                     event_out.event_kind = EV_END;
                     state_next.halted    = 1'b1;
                  end
               end else if (b == OP_DATA_BLOCK || b == OP_SEEK) begin
                  emit                 = 1'b1;
                  event_out.event_kind = EV_HANDOFF;
                  event_out.write_data = b;
               end else begin
                  emit                 = 1'b1;
                  event_out.event_kind = EV_ERROR;
                  event_out.write_data = b;
                  state_next.halted    = 1'b1;
               end
            end
         endcase
      end
   end

endmodule

// ===== sim/tb_vgm_command_stream_parser_top.sv =====
`timescale 1ns / 1ps
// Testbench: command byte stimulus, parser event prediction and scoreboard for the stream parser
module tb_vgm_command_stream_parser_top;
   import vgm_pkg::*;

   localparam int STALL_NONE  = 0;
   localparam int STALL_LIGHT = 1;
   localparam int STALL_HEAVY = 2;

   class stream_event_scoreboard;
      phase_type    phase;
      logic [7:0]   opcode;
      logic [7:0]   operand;
      bit           halted;
      bit           loop_enable;
      rsp_beat_type pending_events[$];
      int           fail_count;
      int           events_checked;
      int           kind_seen[8];

      function new();
         phase          = PH_OPCODE;
         opcode         = '0;
         operand        = '0;
         halted         = 1'b0;
         loop_enable    = 1'b0;
         fail_count     = 0;
         events_checked = 0;
         foreach (kind_seen[k]) kind_seen[k] = 0;
      endfunction

      function void set_loop(bit value);
         loop_enable = value;
      endfunction

      function int pending_count();
         return pending_events.size();
      endfunction

      task report(input string msg);
         $display("[%0t] MISMATCH: %s", $time, msg);
         fail_count++;
      endtask

      function void note_byte(req_beat_type beat);
         rsp_beat_type ev;
         logic [7:0]   code;
         bit           fires;
         code  = beat.stream_byte;
         ev    = '0;
         fires = 1'b1;
         if (halted) return;
         case (phase)
            PH_DATA: begin
               phase         = PH_OPCODE;
               ev.event_kind = EV_TONE;
               ev.reg_addr   = (opcode == OP_TONE_STEREO) ? STEREO_ADDR : 8'h00;
               ev.write_data = code;
               ev.wait_samples = 16'd1;
            end
            PH_ADDR: begin
               operand = code;
               phase   = PH_FMDATA;
               fires   = 1'b0;
            end
            PH_FMDATA: begin
               phase         = PH_OPCODE;
               ev.event_kind = (opcode == OP_FM_PORT1) ? EV_FM1 : EV_FM0;
               ev.reg_addr   = operand;
               ev.write_data = code;
               ev.wait_samples = 16'd1;
            end
            PH_CNT_LO: begin
               operand = code;
               phase   = PH_CNT_HI;
               fires   = 1'b0;
            end
            PH_CNT_HI: begin
               phase           = PH_OPCODE;
               ev.event_kind   = EV_WAIT;
               ev.wait_samples = {code, operand};
            end
            default: begin
               phase  = PH_OPCODE;
               opcode = code;
               if (code == OP_TONE_STEREO || code == OP_TONE) begin
                  phase = PH_DATA;
                  fires = 1'b0;
               end else if (code == OP_FM_PORT0 || code == OP_FM_PORT1) begin
                  phase = PH_ADDR;
                  fires = 1'b0;
               end else if (code == OP_WAIT_N) begin
                  phase = PH_CNT_LO;
                  fires = 1'b0;
               end else if (code == OP_WAIT_735) begin
                  ev.event_kind   = EV_WAIT;
                  ev.wait_samples = WAIT_NTSC;
               end else if (code == OP_WAIT_882) begin
                  ev.event_kind   = EV_WAIT;
                  ev.wait_samples = WAIT_PAL;
               end else if (code[7:4] == NIB_WAIT_SHORT) begin
                  ev.event_kind   = EV_WAIT;
                  ev.wait_samples = {12'd0, code[3:0]} + 16'd1;
               end else if (code[7:4] == NIB_PCM_WRITE) begin
                  ev.event_kind   = EV_FM0;
                  ev.reg_addr     = PCM_ADDR;
                  ev.write_data   = beat.pcm_byte;
                  ev.wait_samples = {12'd0, code[3:0]};
                  ev.pcm_advance  = 1'b1;
               end else if (code == OP_END) begin
                  if (loop_enable) begin
                     ev.event_kind = EV_LOOP;
                  end else begin
                     ev.event_kind = EV_END;
                     halted        = 1'b1;
                  end
               end else if (code == OP_DATA_BLOCK || code == OP_SEEK) begin
                  ev.event_kind = EV_HANDOFF;
                  ev.write_data = code;
               end else begin
                  ev.event_kind = EV_ERROR;
                  ev.write_data = code;
                  halted        = 1'b1;
               end
            end
         endcase
         if (fires) pending_events.push_back(ev);
      endfunction

      task check_event(input rsp_beat_type got);
         rsp_beat_type want;
         if (pending_events.size() == 0) begin
            report($sformatf("event with nothing pending: kind %0d data %02h",
                             got.event_kind, got.write_data));
            return;
         end
         want = pending_events.pop_front();
         events_checked++;
         kind_seen[want.event_kind]++;
         if (got.event_kind !== want.event_kind)
            report($sformatf("event_kind got %0d want %0d", got.event_kind, want.event_kind));
         if (got.reg_addr !== want.reg_addr)
            report($sformatf("reg_addr got %02h want %02h", got.reg_addr, want.reg_addr));
         if (got.write_data !== want.write_data)
            report($sformatf("write_data got %02h want %02h", got.write_data, want.write_data));
         if (got.wait_samples !== want.wait_samples)
            report($sformatf("wait_samples got %0d want %0d",
                             got.wait_samples, want.wait_samples));
         if (got.pcm_advance !== want.pcm_advance)
            report($sformatf("pcm_advance got %0b want %0b", got.pcm_advance, want.pcm_advance));
      endtask
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_beat_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_beat_type rsp_data;
   logic         csr_write_enable = 1'b0;
   logic         csr_write_data = 1'b0;

   stream_event_scoreboard tracker = new();

   int beats_sent  = 0;
   int burst_left  = 0;
   int loop_writes = 0;
   int stall_mode  = STALL_NONE;
   int stall_left  = 0;

   vgm_command_stream_parser_top DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Run timed out");
      $display("Verification failed");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) tracker.check_event(rsp_data);
         if (req_valid && !req_stall) tracker.note_byte(req_data);
      end
   end

   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(STALL_NONE, STALL_HEAVY);
         stall_left = $urandom_range(32, 256);
      end
      stall_left--;
      case (stall_mode)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 2) == 0);
         default:     rsp_stall <= ($urandom_range(0, 7) != 0);
      endcase
   end

   function automatic logic [7:0] rand_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [7:0] operand_byte();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return rand_byte();
      endcase
   endfunction

   function automatic bit is_known(logic [7:0] code);
      case (code)
         OP_TONE_STEREO, OP_TONE, OP_FM_PORT0, OP_FM_PORT1, OP_WAIT_N, OP_WAIT_735,
         OP_WAIT_882, OP_END, OP_DATA_BLOCK, OP_SEEK: return 1'b1;
         default: return code[7:4] == NIB_WAIT_SHORT || code[7:4] == NIB_PCM_WRITE;
      endcase
   endfunction

   task automatic send_beat(input logic [7:0] code, input logic [7:0] pcm);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= {code, pcm};
      do @(posedge clock); while (req_stall);
      beats_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (tracker.pending_count() > 0) @(posedge clock);
   endtask

   task automatic write_loop(input bit value);
      drain();
      // let a trailing operand byte clear the pipeline
      repeat (4) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      tracker.set_loop(value);
      loop_writes++;
   endtask

   task automatic send_command(input bit loop_ok);
      logic [7:0] lo;
      logic [7:0] hi;
      case ($urandom_range(0, loop_ok ? 10 : 9))
         0: begin
            send_beat(OP_TONE_STEREO, rand_byte());
            send_beat(operand_byte(), rand_byte());
         end
         1: begin
            send_beat(OP_TONE, rand_byte());
            send_beat(operand_byte(), rand_byte());
         end
         2, 3: begin
            send_beat(($urandom_range(0, 1) == 0) ? OP_FM_PORT0 : OP_FM_PORT1, rand_byte());
            send_beat(operand_byte(), rand_byte());
            send_beat(operand_byte(), rand_byte());
         end
         4: begin
            lo = operand_byte();
            hi = operand_byte();
            if ($urandom_range(0, 7) == 0) begin
               lo = 8'h00;
               hi = 8'h00;
            end
            send_beat(OP_WAIT_N, rand_byte());
            send_beat(lo, rand_byte());
            send_beat(hi, rand_byte());
         end
         5: send_beat(OP_WAIT_735, rand_byte());
         6: send_beat(OP_WAIT_882, rand_byte());
         7: send_beat({NIB_WAIT_SHORT, 4'($urandom_range(0, 15))}, rand_byte());
         8: send_beat({NIB_PCM_WRITE, 4'($urandom_range(0, 15))}, operand_byte());
         9: send_beat(($urandom_range(0, 1) == 0) ? OP_DATA_BLOCK : OP_SEEK, rand_byte());
         default: send_beat(OP_END, rand_byte());
      endcase
   endtask

   initial begin
      int         target;
      bit         end_by_error;
      logic [7:0] bad;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      write_loop(1'b0);
      send_beat(OP_TONE_STEREO, rand_byte());
      send_beat(8'h00, rand_byte());
      send_beat(OP_TONE, rand_byte());
      send_beat(8'hFF, rand_byte());
      send_beat(OP_FM_PORT0, rand_byte());
      send_beat(8'h00, rand_byte());
      send_beat(8'hFF, rand_byte());
      send_beat(OP_FM_PORT1, rand_byte());
      send_beat(8'hFF, rand_byte());
      send_beat(8'h00, rand_byte());
      send_beat(OP_WAIT_N, rand_byte());
      send_beat(8'h00, rand_byte());
      send_beat(8'h00, rand_byte());
      send_beat(OP_WAIT_N, rand_byte());
      send_beat(8'hFF, rand_byte());
      send_beat(8'hFF, rand_byte());
      send_beat(OP_WAIT_735, rand_byte());
      send_beat(OP_WAIT_882, rand_byte());
      send_beat({NIB_WAIT_SHORT, 4'h0}, rand_byte());
      send_beat({NIB_WAIT_SHORT, 4'hF}, rand_byte());
      send_beat({NIB_PCM_WRITE, 4'h0}, 8'h00);
      send_beat({NIB_PCM_WRITE, 4'hF}, 8'hFF);
      send_beat(OP_DATA_BLOCK, rand_byte());
      send_beat(OP_SEEK, rand_byte());
      write_loop(1'b1);
      send_beat(OP_END, rand_byte());

      for (int p = 0; p < 5; p++) begin
         write_loop(p % 2 == 1);
         target = 25 + (p + 1) * 203;
         while (beats_sent < target) begin
            send_command(tracker.loop_enable);
            if ($urandom_range(0, 149) == 0) drain();
         end
      end

      // halt the parser, then feed bytes it must drop
      end_by_error = 1'($urandom_range(0, 1));
      if (end_by_error) begin
         write_loop(1'($urandom_range(0, 1)));
         do bad = rand_byte(); while (is_known(bad));
         send_beat(bad, rand_byte());
      end else begin
         write_loop(1'b0);
         send_beat(OP_END, rand_byte());
      end
      repeat (8) send_beat(rand_byte(), rand_byte());
      req_valid <= 1'b0;

      while (tracker.pending_count() > 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Sent %0d stream bytes over %0d loop_enable settings, %0d events checked, %s",
               beats_sent, loop_writes, tracker.events_checked,
               end_by_error ? "halted on an unknown opcode" : "halted on end of data");
      $display("Events: tone %0d fm0 %0d fm1 %0d wait %0d loop %0d end %0d handoff %0d error %0d",
               tracker.kind_seen[EV_TONE], tracker.kind_seen[EV_FM0], tracker.kind_seen[EV_FM1],
               tracker.kind_seen[EV_WAIT], tracker.kind_seen[EV_LOOP], tracker.kind_seen[EV_END],
               tracker.kind_seen[EV_HANDOFF], tracker.kind_seen[EV_ERROR]);
      if (tracker.fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
